/* hw/rtl/pip_pkg.sv */
package pip_pkg;

   localparam int COORD_W          = 32;
   localparam int DIFF_W           = COORD_W + 1;
   localparam int PROD_W           = 2 * DIFF_W;
   localparam int IDX_W            = 6;
   localparam int CNT_W            = 7;
   localparam int DEF_MAX_VERTICES = 64;

   localparam logic [CNT_W-1:0] DEF_VERTEX_COUNT = CNT_W'(3);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // One stored vertex; x sits in the low half of the word.
   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vertex_type;

   // One edge handed to the crossing unit.
   typedef struct packed {
      logic       valid;
      vertex_type a;
      vertex_type b;
   } edge_req_type;

   // Verdict for one edge.
   typedef struct packed {
      logic valid;
      logic hit;
   } edge_res_type;

endpackage

/* hw/rtl/pip_ifs.sv */
interface pip_req_if;
   import pip_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [IDX_W-1:0]          vertex_index;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;

   modport source (output valid, cmd, vertex_index, coord_x, coord_y, input ready);
   modport sink   (input valid, cmd, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_rsp_if;
   import pip_pkg::*;

   logic             valid;
   logic             ready;
   logic             inside_res;
   logic [CNT_W-1:0] crossing_count;

   modport source (output valid, inside_res, crossing_count, input ready);
   modport sink   (input valid, inside_res, crossing_count, output ready);
endinterface

/* hw/rtl/pip_vstore.sv */
module pip_vstore #(
   parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
   localparam int AW = $clog2(MAX_VERTICES)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pip_pkg::vertex_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output pip_pkg::vertex_type rd_data
);
   import pip_pkg::*;

   vertex_type mem [MAX_VERTICES];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/pip_edge_unit.sv */
module pip_edge_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  pip_pkg::edge_req_type         edge_req,
   input  logic signed [pip_pkg::COORD_W-1:0] px,
   input  logic signed [pip_pkg::COORD_W-1:0] py,
   output pip_pkg::edge_res_type         edge_res
);
   import pip_pkg::*;

   // Stage 1: order the endpoints by y, test the half-open y span, take differences.
   logic                      swap;
   logic signed [COORD_W-1:0] xa, ya, xb, yb;
   logic                      s1_vld_ff, s1_rng_ff;
   logic signed [DIFF_W-1:0]  dxp_ff, dye_ff, dyp_ff, dxe_ff;
   // Stage 2: the two cross products.
   logic                      s2_vld_ff, s2_rng_ff;
   logic signed [PROD_W-1:0]  lhs_ff, rhs_ff;
   // Stage 3: verdict.
   logic                      s3_vld_ff, s3_hit_ff;

   always_comb begin
      swap = edge_req.a.y > edge_req.b.y;
      xa   = swap ? edge_req.b.x : edge_req.a.x;
      ya   = swap ? edge_req.b.y : edge_req.a.y;
      xb   = swap ? edge_req.a.x : edge_req.b.x;
      yb   = swap ? edge_req.a.y : edge_req.b.y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= edge_req.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_rng_ff <= (ya <= py) && (py < yb);
      dxp_ff    <= DIFF_W'(px) - DIFF_W'(xa);
      dye_ff    <= DIFF_W'(yb) - DIFF_W'(ya);
      dyp_ff    <= DIFF_W'(py) - DIFF_W'(ya);
      dxe_ff    <= DIFF_W'(xb) - DIFF_W'(xa);

      s2_rng_ff <= s1_rng_ff;
      lhs_ff    <= PROD_W'(dxp_ff) * PROD_W'(dye_ff);
      rhs_ff    <= PROD_W'(dyp_ff) * PROD_W'(dxe_ff);

      s3_hit_ff <= s2_vld_ff && s2_rng_ff && (lhs_ff < rhs_ff);
   end

   assign edge_res.valid = s3_vld_ff;
   assign edge_res.hit   = s3_hit_ff;

endmodule

/* hw/rtl/point_in_polygon_test_unit.sv */
// Channel   Direction  Payload                                     Handshake
// req_chan  in         cmd, vertex_index, coord_x, coord_y         valid/ready
// rsp_chan  out        inside_res, crossing_count                  valid/ready
// csr       in         csr_wr_data (vertex_count)                  csr_wr_en
//
// A load transaction writes one vertex slot; a load past the end of the memory is dropped.
// A query transaction holds off the next acceptance until every edge of the polygon in
// use has a verdict and its result is posted; a vertex count of zero walks no edges.
// The single read port of the vertex memory delivers one vertex, so one edge, per cycle,
// and the crossing pipeline adds three stages.
// Reset is synchronous; the vertex memory is not cleared and the vertex count returns to 3.
// Input transactions are taken only while no query is walking and reset is low. A finished
// result waits in the output register while new transactions are taken; a query that
// finishes while an older result is still waiting holds until that result is taken.
module point_in_polygon_test_unit #(
   parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
   input  logic                        clock,
   input  logic                        reset,
   pip_req_if.sink                     req_chan,
   pip_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [pip_pkg::CNT_W-1:0]   csr_wr_data
);
   import pip_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   state_type                 state_ff;
   logic [CNT_W-1:0]          vcount_ff;     // configured vertex count
   logic [CNT_W-1:0]          n_ff;          // vertex count in use by the current query
   logic [CNT_W-1:0]          issue_ff;      // memory reads issued
   logic [CNT_W-1:0]          done_ff;       // edge verdicts received
   logic [CNT_W-1:0]          count_ff;      // crossings found
   logic                      rd_vld_ff;
   logic                      rd_last_ff;
   logic                      first_ff;
   logic                      close_ff;
   vertex_type                v0_ff;
   vertex_type                prev_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic                      rsp_vld_ff;
   logic                      rsp_inside_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   logic                      req_fire;
   logic                      load_fire;
   logic                      query_fire;
   logic [CNT_W-1:0]          n_eff;
   logic                      rd_en;
   logic                      slot_ok;
   logic                      finish;
   vertex_type                wr_vertex;
   vertex_type                rd_data;
   edge_req_type              edge_req;
   edge_res_type              edge_res;

   // The vertex count is capped at the memory depth.
   assign n_eff = (32'(vcount_ff) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : vcount_ff;

   assign req_chan.ready = (state_ff == S_IDLE) && !reset;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load_fire      = req_fire && (req_chan.cmd == CMD_LOAD);
   assign query_fire     = req_fire && (req_chan.cmd == CMD_QUERY);

   // A load aimed past the end of the memory is dropped.
   assign slot_ok     = 32'(req_chan.vertex_index) < MAX_VERTICES;
   assign wr_vertex.x = req_chan.coord_x;
   assign wr_vertex.y = req_chan.coord_y;

   // Reads walk vertex 0 through n-1, one per cycle.
   assign rd_en = (state_ff == S_WALK) && (issue_ff < n_ff);

   // Each returning vertex after the first closes an edge with the one before it.
   // The closing edge back to vertex 0 goes out in the cycle after the last vertex returns.
   always_comb begin
      edge_req.valid = (rd_vld_ff && !first_ff) || close_ff;
      edge_req.a     = prev_ff;
      edge_req.b     = close_ff ? v0_ff : rd_data;
   end

   // The query is complete once every edge has a verdict and the output register is free or being emptied.
   assign finish = (state_ff == S_WALK) && (done_ff == n_ff) &&
                   (!rsp_vld_ff || rsp_chan.ready);

   pip_vstore #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_vstore (
      .clock   (clock),
      .wr_en   (load_fire && slot_ok),
      .wr_addr (AW'(req_chan.vertex_index)),
      .wr_data (wr_vertex),
      .rd_en   (rd_en),
      .rd_addr (AW'(issue_ff)),
      .rd_data (rd_data)
   );

   pip_edge_unit u_edge (
      .clock    (clock),
      .reset    (reset),
      .edge_req (edge_req),
      .px       (px_ff),
      .py       (py_ff),
      .edge_res (edge_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         vcount_ff  <= DEF_VERTEX_COUNT;
         rsp_vld_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         close_ff   <= 1'b0;
         first_ff   <= 1'b0;
         issue_ff   <= '0;
         done_ff    <= '0;
         count_ff   <= '0;
         n_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end

         rd_vld_ff  <= rd_en;
         rd_last_ff <= (issue_ff == (n_ff - CNT_W'(1)));
         if (rd_en) begin
            issue_ff <= issue_ff + CNT_W'(1);
         end

         if (rd_vld_ff) begin
            if (first_ff) begin
               v0_ff    <= rd_data;
               first_ff <= 1'b0;
            end
            prev_ff  <= rd_data;
            close_ff <= rd_last_ff;
         end else begin
            close_ff <= 1'b0;
         end

         if (edge_res.valid) begin
            done_ff  <= done_ff + CNT_W'(1);
            count_ff <= count_ff + CNT_W'(edge_res.hit);
         end

         // A result taken in the same cycle that a new one posts is replaced below.
         if (rsp_vld_ff && rsp_chan.ready && !finish) begin
            rsp_vld_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (query_fire) begin
                  state_ff <= S_WALK;
                  n_ff     <= n_eff;
                  px_ff    <= req_chan.coord_x;
                  py_ff    <= req_chan.coord_y;
                  issue_ff <= '0;
                  done_ff  <= '0;
                  count_ff <= '0;
                  first_ff <= 1'b1;
               end
            end
            S_WALK: begin
               if (finish) begin
                  state_ff      <= S_IDLE;
                  rsp_vld_ff    <= 1'b1;
                  rsp_inside_ff <= count_ff[0];
                  rsp_count_ff  <= count_ff;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.inside_res     = rsp_inside_ff;
   assign rsp_chan.crossing_count = rsp_count_ff;

   // Verdicts can never outrun the edges of the polygon in use.
   a_done_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (done_ff <= n_ff))
      else $error("more edge verdicts than edges");

   // Crossings are a subset of the verdicts.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= done_ff)
      else $error("crossing count exceeds edges tested");

   // The memory is read only while a query walks the polygon.
   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (state_ff == S_WALK))
      else $error("vertex read outside a query");

   // A completed query always presents its result in the next cycle.
   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_vld_ff && (state_ff == S_IDLE)))
      else $error("finished query did not post a result");

endmodule

/* tb/polygon_verdict_checker.sv */
module polygon_verdict_checker (
   input  logic                      clock,
   input  logic                      reset,
   pip_req_if                        req_mon,
   pip_rsp_if                        rsp_mon,
   input  logic                      csr_wr_en,
   input  logic [pip_pkg::CNT_W-1:0] csr_wr_data,
   output int                        mismatch_total,
   output int                        results_pending,
   output int                        verdicts_checked,
   output int                        inside_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   localparam int PRINT_CAP = 50;

   typedef struct {
      logic                      is_inside;
      logic [CNT_W-1:0]          crossings;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
   } ray_verdict_type;

   vertex_type       polygon [DEF_MAX_VERTICES];
   logic [CNT_W-1:0] sides;
   ray_verdict_type  pending_verdicts [$];
   ray_verdict_type  oldest;

   initial begin
      mismatch_total   = 0;
      results_pending  = 0;
      verdicts_checked = 0;
      inside_seen      = 0;
      sides            = DEF_VERTEX_COUNT;
   end

   task automatic report_mismatch(input string what);
      mismatch_total++;
      if (mismatch_total <= PRINT_CAP) begin
         $display("[%0t] MISMATCH: %s", $realtime, what);
      end
   endtask

   // Half-open in y, strictly right of the point, compared by cross-multiplying.
   function automatic bit ray_hits_edge(input vertex_type va, input vertex_type vb,
                                        input logic signed [COORD_W-1:0] px,
                                        input logic signed [COORD_W-1:0] py);
      logic signed [DIFF_W-1:0] lo_x, lo_y, hi_x, hi_y, qx, qy;
      logic signed [PROD_W-1:0] lhs, rhs;
      if (va.y <= vb.y) begin
         lo_x = DIFF_W'(va.x);
         lo_y = DIFF_W'(va.y);
         hi_x = DIFF_W'(vb.x);
         hi_y = DIFF_W'(vb.y);
      end else begin
         lo_x = DIFF_W'(vb.x);
         lo_y = DIFF_W'(vb.y);
         hi_x = DIFF_W'(va.x);
         hi_y = DIFF_W'(va.y);
      end
      qx = DIFF_W'(px);
      qy = DIFF_W'(py);
      if (!(lo_y <= qy && qy < hi_y)) begin
         return 1'b0;
      end
      lhs = PROD_W'(qx - lo_x) * PROD_W'(hi_y - lo_y);
      rhs = PROD_W'(qy - lo_y) * PROD_W'(hi_x - lo_x);
      return lhs < rhs;
   endfunction

   function automatic ray_verdict_type count_ray_crossings(
         input logic signed [COORD_W-1:0] px,
         input logic signed [COORD_W-1:0] py);
      int unsigned     walked;
      int unsigned     hits;
      int unsigned     nxt;
      int unsigned     i;
      ray_verdict_type verdict;
      walked = (sides > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : sides;
      hits   = 0;
      for (i = 0; i < walked; i++) begin
         nxt = (i + 1 == walked) ? 0 : i + 1;
         if (ray_hits_edge(polygon[IDX_W'(i)], polygon[IDX_W'(nxt)], px, py)) begin
            hits++;
         end
      end
      verdict.is_inside = hits[0];
      verdict.crossings = CNT_W'(hits);
      verdict.px        = px;
      verdict.py        = py;
      return verdict;
   endfunction

   // Results are matched before new queries are predicted, so a result and a query
   // accepted at the same edge can never pair up with each other.
   always @(posedge clock) begin
      if (reset) begin
         sides = DEF_VERTEX_COUNT;
         pending_verdicts.delete();
      end else begin
         if (csr_wr_en) begin
            sides = csr_wr_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("result inside=%0b count=%0d with no query outstanding",
                                         rsp_mon.inside_res, rsp_mon.crossing_count));
            end else begin
               oldest = pending_verdicts.pop_front();
               if (rsp_mon.inside_res !== oldest.is_inside) begin
                  report_mismatch($sformatf("point (%h,%h): inside_res %b, predicted %b",
                                            oldest.px, oldest.py, rsp_mon.inside_res,
                                            oldest.is_inside));
               end
               if (rsp_mon.crossing_count !== oldest.crossings) begin
                  report_mismatch($sformatf("point (%h,%h): crossing_count %0d, predicted %0d",
                                            oldest.px, oldest.py, rsp_mon.crossing_count,
                                            oldest.crossings));
               end
               verdicts_checked++;
               if (oldest.is_inside) begin
                  inside_seen++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.cmd == CMD_LOAD) begin
               polygon[req_mon.vertex_index] = {req_mon.coord_y, req_mon.coord_x};
            end else begin
               pending_verdicts.push_back(count_ray_crossings(req_mon.coord_x, req_mon.coord_y));
            end
         end
      end
      results_pending = pending_verdicts.size();
   end

endmodule

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   // One in Q16.16, and the two extremes of a coordinate.
   localparam int                  ONE          = 65536;
   localparam logic signed [31:0]  COORD_MIN    = 32'sh8000_0000;
   localparam logic signed [31:0]  COORD_MAX    = 32'sh7FFF_FFFF;
   localparam int                  TARGET_ITEMS = 1650;
   // Long enough for any walk still in flight, its vertex reads and the crossing pipeline,
   // to finish before the vertex count is changed or the run ends.
   localparam int                  DRAIN_CYCLES = 100;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   pip_req_if req_if ();
   pip_rsp_if rsp_if ();

   // When set, neither the sender nor the receiver inserts idle cycles.
   bit steady_flow;

   int mismatch_total;
   int results_pending;
   int verdicts_checked;
   int inside_seen;
   int items_sent;
   int loads_sent;
   int sizes_tried;

   // Copy of what has been loaded, so query points can be aimed at vertex heights.
   logic signed [31:0] shadow_x [DEF_MAX_VERTICES];
   logic signed [31:0] shadow_y [DEF_MAX_VERTICES];

   point_in_polygon_test_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   polygon_verdict_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_total   (mismatch_total),
      .results_pending  (results_pending),
      .verdicts_checked (verdicts_checked),
      .inside_seen      (inside_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog. If the run has not ended when this delay runs out, the block is
   // declared hung.
   initial begin
      #2_000_000;
      $display("Timeout: the block stopped making progress.");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side. Before each transaction the receiver draws a random stall, and
   // holds ready high until the transaction is taken. Ready is only lowered when
   // a stall is drawn, so it never gets two updates in one step.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // A random coordinate spread over about +/- 2^shift, with the two extremes
   // mixed in now and then so every bit of the field toggles.
   function automatic logic signed [31:0] coord_at(input int shift);
      int unsigned pick;
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
         return COORD_MIN;
      end
      if (pick == 1) begin
         return COORD_MAX;
      end
      return $signed($urandom) >>> (31 - shift);
   endfunction

   // Presents one transaction after a random gap and returns at the edge that
   // accepts it. Valid is left high so back-to-back transactions need no toggle.
   task automatic send_item(input logic cmd, input logic [IDX_W-1:0] slot,
                            input logic signed [31:0] x, input logic signed [31:0] y);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.cmd          <= cmd;
      req_if.vertex_index <= slot;
      req_if.coord_x      <= x;
      req_if.coord_y      <= y;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      if (cmd == CMD_LOAD) begin
         loads_sent++;
         shadow_x[slot] = x;
         shadow_y[slot] = y;
      end
   endtask

   task automatic load_vertex(input logic [IDX_W-1:0] slot,
                              input logic signed [31:0] x, input logic signed [31:0] y);
      send_item(CMD_LOAD, slot, x, y);
   endtask

   // The slot field means nothing to a query, so it carries random bits.
   task automatic ask_point(input logic signed [31:0] x, input logic signed [31:0] y);
      send_item(CMD_QUERY, IDX_W'($urandom), x, y);
   endtask

   // The vertex count may only change while the block is idle: wait for every
   // predicted verdict to come back, then let any walk still in flight finish.
   // Pending is read at the falling edge, away from the checker's update.
   task automatic set_vertex_count(input logic [CNT_W-1:0] value);
      req_if.valid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sizes_tried++;
   endtask

   initial begin
      int                  phase;
      int                  shift;
      int                  used;
      int                  slot;
      int                  queries;
      int                  pick;
      logic [CNT_W-1:0]    count;
      logic signed [31:0]  px;
      logic signed [31:0]  py;
      logic [CNT_W-1:0]    size_sweep [9];

      size_sweep = '{7'd64, 7'd3, 7'd127, 7'd65, 7'd4, 7'd0, 7'd1, 7'd2, 7'd63};

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_if.valid        = 1'b0;
      req_if.cmd          = CMD_LOAD;
      req_if.vertex_index = '0;
      req_if.coord_x      = '0;
      req_if.coord_y      = '0;
      steady_flow         = 1'b0;
      items_sent          = 0;
      loads_sent          = 0;
      sizes_tried         = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The reset vertex count of three is used first with a
      // right triangle at the origin, so only slots 0 to 2 are ever read.
      load_vertex(0, 0, 0);
      load_vertex(1, 10 * ONE, 0);
      load_vertex(2, 0, 10 * ONE);
      ask_point(ONE, ONE);                  // plainly inside
      ask_point(20 * ONE, ONE);             // right of everything
      ask_point(-5 * ONE, ONE);             // ray crosses the vertical side and the hypotenuse
      ask_point(-ONE, 0);                   // at the height of the horizontal edge
      ask_point(-ONE, 10 * ONE);            // at the apex, excluded by the half-open rule
      ask_point(5 * ONE, 5 * ONE);          // exactly on the hypotenuse
      ask_point(COORD_MIN, COORD_MIN);
      ask_point(COORD_MAX, COORD_MAX);
      ask_point(COORD_MIN, 5 * ONE);

      // A triangle spanning the whole coordinate range stresses the products.
      load_vertex(0, COORD_MIN, COORD_MIN);
      load_vertex(1, COORD_MAX, COORD_MIN);
      load_vertex(2, 0, COORD_MAX);
      ask_point(0, 0);
      ask_point(COORD_MIN, 0);
      ask_point(COORD_MAX, COORD_MAX - 1);
      ask_point(COORD_MIN, COORD_MIN);

      // Degenerate vertex counts: no edges at all, one vertex closing on itself,
      // and two vertices walked there and back.
      set_vertex_count(0);
      ask_point(0, 0);
      set_vertex_count(1);
      ask_point(COORD_MIN, COORD_MIN);
      load_vertex(1, ONE, 3 * ONE);
      set_vertex_count(2);
      ask_point(COORD_MIN, 0);
      ask_point(2 * ONE, 0);

      // Random part. Every slot is loaded once before any larger polygon is
      // used, so no query ever reads a slot that was never written.
      shift = 20;
      for (slot = 0; slot < DEF_MAX_VERTICES; slot++) begin
         load_vertex(IDX_W'(slot), coord_at(shift), coord_at(shift));
      end

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         if (phase < $size(size_sweep)) begin
            count = size_sweep[phase];
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               count = CNT_W'($urandom_range(0, 2));
            end else if (pick == 1) begin
               count = CNT_W'($urandom_range(65, 127));
            end else begin
               count = CNT_W'($urandom_range(3, 64));
            end
         end
         phase++;
         shift       = ($urandom_range(0, 4) == 0) ? 31 : $urandom_range(2, 30);
         steady_flow = ($urandom_range(0, 3) == 0);
         set_vertex_count(count);
         used = (count > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : count;

         // Reshape the polygon in use at this phase's scale, so that the query
         // points land around it and the crossing counts vary.
         for (slot = 0; slot < used; slot++) begin
            load_vertex(IDX_W'(slot), coord_at(shift), coord_at(shift));
         end

         queries = $urandom_range(20, 40);
         while (queries > 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
               // Occasional reload of a single slot between queries.
               load_vertex(IDX_W'($urandom_range(0, DEF_MAX_VERTICES - 1)), coord_at(shift),
                           coord_at(shift));
            end else begin
               slot = (used == 0) ? 0 : $urandom_range(0, used - 1);
               if (pick == 3) begin
                  px = $urandom;
                  py = $urandom;
               end else if (pick < 8) begin
                  // Exactly at a vertex height, where the half-open rule matters.
                  px = coord_at(shift);
                  py = shadow_y[IDX_W'(slot)];
               end else if (pick == 8) begin
                  px = shadow_x[IDX_W'(slot)];
                  py = shadow_y[IDX_W'(slot)];
               end else begin
                  px = coord_at(shift);
                  py = coord_at(shift);
               end
               ask_point(px, py);
               queries--;
            end
         end
      end

      // All stimulus is in; wait for the last verdicts and let the block settle.
      req_if.valid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d transactions, %0d of them vertex loads, over %0d vertex counts.",
               items_sent, loads_sent, sizes_tried);
      $display("Checked %0d query verdicts, %0d of them inside the polygon.",
               verdicts_checked, inside_seen);
      if (mismatch_total == 0 && results_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/pip_pkg.sv
hw/rtl/pip_ifs.sv
hw/rtl/pip_vstore.sv
hw/rtl/pip_edge_unit.sv
hw/rtl/point_in_polygon_test_unit.sv
tb/polygon_verdict_checker.sv
tb/tb_top.sv
